/* src/stepper_absolute_angle_positioner_unit_macros.svh */
// Assertion helpers for the positioner core RTL.
// Each macro expects a clock named aclk and an active-low reset named aresetn.
`ifndef STEPPER_ABSOLUTE_ANGLE_POSITIONER_UNIT_MACROS_SVH
`define STEPPER_ABSOLUTE_ANGLE_POSITIONER_UNIT_MACROS_SVH

// Same-cycle implication.
`define SAPP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("positioner check failed");

// Next-cycle implication.
`define SAPP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("positioner check failed");

`endif

/* src/sapp_pkg.sv */
package sapp_pkg;

    // Geometry of one revolution.
    localparam int STEPS_PER_TURN = 3200;
    localparam int DEG_PER_TURN   = 360;
    localparam int MAX_ANGLE      = DEG_PER_TURN - 1;
    localparam int HALF_STEPS     = STEPS_PER_TURN / 2;

    // Field widths.
    localparam int ANGLE_W = 9;
    localparam int POS_W   = 12;
    localparam int STEPS_W = 11;
    localparam int DELTA_W = POS_W + 1;

    // Angle to step target: floor(angle * STEPS / 360) as a multiply by a
    // rounded-up reciprocal and a shift. The rounding error stays far below
    // one ninth over the legal angle range, so the floor is exact.
    localparam int RECIP_SHIFT = 20;
    localparam longint unsigned TARGET_MUL =
        (longint'(STEPS_PER_TURN) * (64'd1 << RECIP_SHIFT) + DEG_PER_TURN - 1) / DEG_PER_TURN;
    localparam int MUL_W  = 24;
    localparam int PROD_W = ANGLE_W + MUL_W;

    localparam logic signed [DELTA_W-1:0] HALF_DELTA = DELTA_W'(HALF_STEPS);
    localparam logic signed [DELTA_W-1:0] TURN_DELTA = DELTA_W'(STEPS_PER_TURN);

    // Item kinds carried on tuser.
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    // Motion direction state.
    typedef enum logic [1:0] {
        RUN_IDLE = 2'd0,
        RUN_FWD  = 2'd1,
        RUN_REV  = 2'd3
    } run_dir_t;

    // One decoded input item as held in the input register.
    typedef struct packed {
        logic             opcode;
        logic             bad_angle;
        logic [POS_W-1:0] target;
    } item_t;

    // One result item.
    typedef struct packed {
        logic               angle_error;
        logic [STEPS_W-1:0] steps_left;
        logic [POS_W-1:0]   position_steps;
        logic               enable_n;
        logic               dir_level;
        logic               pulse_level;
    } result_t;

endpackage

/* src/sapp_target.sv */
module sapp_target (
    input  logic [sapp_pkg::ANGLE_W-1:0] angle_deg,
    output logic [sapp_pkg::POS_W-1:0]   target,
    output logic                         bad_angle
);

    logic [sapp_pkg::PROD_W-1:0] product;

    // Scale degrees to microsteps with a constant reciprocal multiply.
    assign product = sapp_pkg::PROD_W'(angle_deg) *
                     sapp_pkg::PROD_W'(sapp_pkg::TARGET_MUL);
    assign target  = product[sapp_pkg::RECIP_SHIFT +: sapp_pkg::POS_W];

    // Angles of a full turn (360 degrees) or more are rejected.
    assign bad_angle = (angle_deg > sapp_pkg::ANGLE_W'(sapp_pkg::MAX_ANGLE));

endmodule

/* src/sapp_core.sv */
`include "stepper_absolute_angle_positioner_unit_macros.svh"

module sapp_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  sapp_pkg::item_t   item,
    output sapp_pkg::result_t result
);

    logic [sapp_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [sapp_pkg::STEPS_W-1:0] steps_reg, steps_next;
    sapp_pkg::run_dir_t           run_reg, run_next;
    logic                         pulse_reg, pulse_next;
    logic                         dir_reg, dir_next;
    logic                         en_n_reg, en_n_next;
    logic                         err_reg;

    logic signed [sapp_pkg::DELTA_W-1:0] delta_raw;
    logic signed [sapp_pkg::DELTA_W-1:0] delta_wrap;
    logic signed [sapp_pkg::DELTA_W-1:0] delta_neg;

    // Signed distance to the target, folded onto the shorter way round.
    always_comb begin
        delta_raw = $signed({1'b0, item.target}) - $signed({1'b0, pos_reg});
        if (delta_raw > sapp_pkg::HALF_DELTA) begin
            delta_wrap = delta_raw - sapp_pkg::TURN_DELTA;
        end else if (delta_raw < -sapp_pkg::HALF_DELTA) begin
            delta_wrap = delta_raw + sapp_pkg::TURN_DELTA;
        end else begin
            delta_wrap = delta_raw;
        end
        delta_neg = -delta_wrap;
    end

    // Next state for a tick or a command.
    always_comb begin
        pos_next   = pos_reg;
        steps_next = steps_reg;
        run_next   = run_reg;
        pulse_next = pulse_reg;
        dir_next   = dir_reg;
        en_n_next  = en_n_reg;
        if (item.opcode == sapp_pkg::OP_TICK) begin
            if (run_reg != sapp_pkg::RUN_IDLE && steps_reg != '0) begin
                if (!pulse_reg) begin
                    pulse_next = 1'b1;
                end else begin
                    // Falling edge issues one step.
                    pulse_next = 1'b0;
                    steps_next = steps_reg - sapp_pkg::STEPS_W'(1);
                    if (run_reg == sapp_pkg::RUN_FWD) begin
                        pos_next = (pos_reg == sapp_pkg::POS_W'(sapp_pkg::STEPS_PER_TURN - 1))
                                 ? '0 : pos_reg + sapp_pkg::POS_W'(1);
                    end else begin
                        pos_next = (pos_reg == '0)
                                 ? sapp_pkg::POS_W'(sapp_pkg::STEPS_PER_TURN - 1)
                                 : pos_reg - sapp_pkg::POS_W'(1);
                    end
                end
            end
        end else if (!item.bad_angle && delta_wrap != '0) begin
            en_n_next = 1'b0;
            if (!delta_wrap[sapp_pkg::DELTA_W-1]) begin
                dir_next   = 1'b0;
                run_next   = sapp_pkg::RUN_FWD;
                steps_next = sapp_pkg::STEPS_W'(delta_wrap);
            end else begin
                dir_next   = 1'b1;
                run_next   = sapp_pkg::RUN_REV;
                steps_next = sapp_pkg::STEPS_W'(delta_neg);
            end
        end
    end

    // Motion state doubles as the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            steps_reg <= '0;
            run_reg   <= sapp_pkg::RUN_IDLE;
            pulse_reg <= 1'b0;
            dir_reg   <= 1'b0;
            en_n_reg  <= 1'b1;
        end else if (advance) begin
            pos_reg   <= pos_next;
            steps_reg <= steps_next;
            run_reg   <= run_next;
            pulse_reg <= pulse_next;
            dir_reg   <= dir_next;
            en_n_reg  <= en_n_next;
        end
    end

    // Error flag belongs to the item only.
    always_ff @(posedge aclk) begin
        if (advance) begin
            err_reg <= (item.opcode == sapp_pkg::OP_COMMAND) && item.bad_angle;
        end
    end

    assign result.angle_error    = err_reg;
    assign result.steps_left     = steps_reg;
    assign result.position_steps = pos_reg;
    assign result.enable_n       = en_n_reg;
    assign result.dir_level      = dir_reg;
    assign result.pulse_level    = pulse_reg;

    `SAPP_ASSERT_NOW(a_steps_need_dir, steps_reg != '0, run_reg != sapp_pkg::RUN_IDLE)
    `SAPP_ASSERT_NOW(a_steps_bound, 1'b1, steps_reg <= sapp_pkg::STEPS_W'(sapp_pkg::HALF_STEPS))
    `SAPP_ASSERT_NOW(a_pos_bound, 1'b1, pos_reg < sapp_pkg::POS_W'(sapp_pkg::STEPS_PER_TURN))
    `SAPP_ASSERT_NOW(a_disabled_idle, en_n_reg, run_reg == sapp_pkg::RUN_IDLE && steps_reg == '0)
    `SAPP_ASSERT_NEXT(a_hold_stalled, !advance, $stable(pos_reg) && $stable(steps_reg))

endmodule

/* src/stepper_absolute_angle_positioner_unit.sv */
// Path: an input beat is taken into the input register, then into the motion
// state register that also holds the result. Throughput: one item per cycle
// while the output is not stalled; the state update is one add, wrap and compare.
// Reset (aresetn low, synchronous): position and step count zero, idle, pulse
// low, driver disabled, both registers empty.
module stepper_absolute_angle_positioner_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [8:0] angle_deg, [15:9] zero
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [0] pulse_level, [1] dir_level, [2] enable_n,
                                   // [14:3] position_steps, [25:15] steps_left,
                                   // [26] angle_error, [31:27] zero
);

    logic                        in_valid_reg, in_valid_next;
    sapp_pkg::item_t             item_reg;
    logic                        out_valid_reg, out_valid_next;
    logic                        advance;
    logic [sapp_pkg::POS_W-1:0]  target;
    logic                        bad_angle;
    sapp_pkg::result_t           result;

    // Degrees to microsteps ahead of the input register.
    sapp_target u_target (
        .angle_deg (s_tdata[sapp_pkg::ANGLE_W-1:0]),
        .target    (target),
        .bad_angle (bad_angle)
    );

    // Pipeline handshake.
    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register payload.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.opcode    <= s_tuser;
            item_reg.bad_angle <= bad_angle;
            item_reg.target    <= target;
        end
    end

    sapp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, result};

endmodule

/* verif/testbench.sv */
module testbench;

    // One pending input item; a hold marker makes the sender wait until the
    // result stream has fully drained.
    typedef struct packed {
        logic       hold;
        logic       opcode;
        logic [8:0] angle;
    } stim_t;

    localparam int IDLE_PCT      = 14;
    localparam int CALM_FIRST    = 700;
    localparam int CALM_LAST     = 850;
    localparam int HOLDOFF_AT    = 400;
    localparam int HOLDOFF_LEN   = 60;
    localparam int RANDOM_ITEMS  = 950;
    localparam int HOLD_AT_ITEM  = 550;
    localparam int SETTLE_CYCLES = 8;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    stim_t             item_backlog[$];
    sapp_pkg::result_t pin_state_expect[$];
    int                items_taken  = 0;
    int                beats_seen   = 0;
    int                mismatches   = 0;
    int                holdoff_left = 0;
    bit                holdoff_done = 1'b0;

    // Shadow of the positioner state.
    logic [sapp_pkg::POS_W-1:0]   pos_now     = '0;
    logic [sapp_pkg::STEPS_W-1:0] steps_now   = '0;
    sapp_pkg::run_dir_t           dir_state   = sapp_pkg::RUN_IDLE;
    logic                         pulse_now   = 1'b0;
    logic                         dir_pin_now = 1'b0;
    logic                         en_n_now    = 1'b1;

    stepper_absolute_angle_positioner_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Apply one item to the shadow state and return the pin levels it leaves.
    function automatic sapp_pkg::result_t advance_motion(logic opcode, logic [8:0] angle);
        sapp_pkg::result_t pins;
        int                target;
        int                delta;
        pins.angle_error = 1'b0;
        if (opcode == sapp_pkg::OP_TICK) begin
            if (dir_state != sapp_pkg::RUN_IDLE && steps_now != 0) begin
                if (!pulse_now) begin
                    pulse_now = 1'b1;
                end else begin
                    // Falling edge: one microstep is issued.
                    pulse_now = 1'b0;
                    steps_now = steps_now - 1'b1;
                    if (dir_state == sapp_pkg::RUN_FWD) begin
                        pos_now = (int'(pos_now) + 1 >= sapp_pkg::STEPS_PER_TURN)
                                ? '0 : pos_now + 1'b1;
                    end else begin
                        pos_now = (pos_now == 0)
                                ? sapp_pkg::POS_W'(sapp_pkg::STEPS_PER_TURN - 1)
                                : pos_now - 1'b1;
                    end
                end
            end
        end else if (int'(angle) > sapp_pkg::MAX_ANGLE) begin
            pins.angle_error = 1'b1;
        end else begin
            // Shortest way round; an exact half turn keeps its sign.
            target = int'(angle) * sapp_pkg::STEPS_PER_TURN / sapp_pkg::DEG_PER_TURN;
            delta  = target - int'(pos_now);
            if (delta > sapp_pkg::HALF_STEPS) delta -= sapp_pkg::STEPS_PER_TURN;
            if (delta < -sapp_pkg::HALF_STEPS) delta += sapp_pkg::STEPS_PER_TURN;
            if (delta > 0) begin
                dir_pin_now = 1'b0;
                dir_state   = sapp_pkg::RUN_FWD;
                steps_now   = sapp_pkg::STEPS_W'(delta);
                en_n_now    = 1'b0;
            end else if (delta < 0) begin
                dir_pin_now = 1'b1;
                dir_state   = sapp_pkg::RUN_REV;
                steps_now   = sapp_pkg::STEPS_W'(-delta);
                en_n_now    = 1'b0;
            end
        end
        pins.pulse_level    = pulse_now;
        pins.dir_level      = dir_pin_now;
        pins.enable_n       = en_n_now;
        pins.position_steps = pos_now;
        pins.steps_left     = steps_now;
        return pins;
    endfunction

    task automatic push_item(logic opcode, logic [8:0] angle);
        stim_t it;
        it.hold   = 1'b0;
        it.opcode = opcode;
        it.angle  = angle;
        item_backlog.push_back(it);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Sender: offers the next pending item when the channel is free, idling at random outside the calm window.
    always @(posedge aclk) begin : sender
        bit    offer;
        stim_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pin_state_expect.push_back(advance_motion(s_tuser, s_tdata[8:0]));
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (item_backlog.size() > 0 && item_backlog[0].hold &&
                    pin_state_expect.size() == 0) begin
                    void'(item_backlog.pop_front());
                end
                offer = item_backlog.size() > 0 && !item_backlog[0].hold;
                if (offer && !(items_taken >= CALM_FIRST && items_taken < CALM_LAST)) begin
                    offer = $urandom_range(0, 99) >= IDLE_PCT;
                end
                if (offer) begin
                    it = item_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'b0, it.angle};
                    s_tuser  <= it.opcode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result beat and stalls at random, once for long.
    always @(posedge aclk) begin : receiver
        sapp_pkg::result_t got;
        sapp_pkg::result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                beats_seen++;
                got = sapp_pkg::result_t'(m_tdata[26:0]);
                if (pin_state_expect.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    want = pin_state_expect.pop_front();
                    check_field("pulse_level", int'(want.pulse_level),
                                int'(got.pulse_level));
                    check_field("dir_level", int'(want.dir_level), int'(got.dir_level));
                    check_field("enable_n", int'(want.enable_n), int'(got.enable_n));
                    check_field("position_steps", int'(want.position_steps),
                                int'(got.position_steps));
                    check_field("steps_left", int'(want.steps_left),
                                int'(got.steps_left));
                    check_field("angle_error", int'(want.angle_error),
                                int'(got.angle_error));
                    check_field("padding", 0, int'(m_tdata[31:27]));
                end
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                m_tready <= 1'b0;
            end else if (!holdoff_done && beats_seen >= HOLDOFF_AT) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_LEN;
                m_tready <= 1'b0;
            end else if (beats_seen >= CALM_FIRST && beats_seen < CALM_LAST) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        int         roll;
        int         pick;
        int         cmd_pct;
        int         last_ang;
        logic [8:0] ang;
        stim_t      marker;

        // Directed part: idle tick, zero move from reset, bad angles,
        // exact forward half turn, zero move and override mid-pulse.
        push_item(sapp_pkg::OP_TICK, 9'h1FF);
        push_item(sapp_pkg::OP_COMMAND, 9'd0);
        push_item(sapp_pkg::OP_COMMAND, 9'd360);
        push_item(sapp_pkg::OP_COMMAND, 9'd511);
        push_item(sapp_pkg::OP_COMMAND, 9'd180);
        push_item(sapp_pkg::OP_TICK, 9'd0);
        push_item(sapp_pkg::OP_COMMAND, 9'd0);
        push_item(sapp_pkg::OP_COMMAND, 9'd359);
        // Nine reverse steps across zero, then an idle tick with steps spent.
        repeat (18) push_item(sapp_pkg::OP_TICK, 9'h155);
        // Exact reverse half turn from 3191, then an override mid-pulse.
        push_item(sapp_pkg::OP_COMMAND, 9'd179);
        push_item(sapp_pkg::OP_TICK, 9'h0AA);
        push_item(sapp_pkg::OP_COMMAND, 9'd180);
        push_item(sapp_pkg::OP_TICK, 9'd0);

        // Random part: phases of frequent commands alternate with phases of
        // long tick runs so that moves run to completion.
        last_ang = 180;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == HOLD_AT_ITEM) begin
                marker = '0;
                marker.hold = 1'b1;
                item_backlog.push_back(marker);
            end
            cmd_pct = ((i / 150) % 2 != 0) ? 4 : 20;
            roll = $urandom_range(0, 99);
            if (roll >= cmd_pct) begin
                push_item(sapp_pkg::OP_TICK, 9'($urandom_range(0, 511)));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    ang = 9'((last_ang + $urandom_range(0, 4) + sapp_pkg::DEG_PER_TURN - 2)
                             % sapp_pkg::DEG_PER_TURN);
                end else if (pick < 90) begin
                    ang = 9'($urandom_range(0, sapp_pkg::MAX_ANGLE));
                end else begin
                    ang = 9'($urandom_range(sapp_pkg::MAX_ANGLE + 1, 511));
                end
                if (int'(ang) <= sapp_pkg::MAX_ANGLE) last_ang = int'(ang);
                push_item(sapp_pkg::OP_COMMAND, ang);
            end
        end

        // Wait for the sender to empty and every result to come back.
        while (item_backlog.size() > 0 || s_tvalid || pin_state_expect.size() > 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pin_state_expect.size() == 0) begin
            $display("stepper_absolute_angle_positioner_unit verification clean");
        end else begin
            $display("stepper_absolute_angle_positioner_unit verification failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #4000000;
        $display("stepper_absolute_angle_positioner_unit verification failed");
        $finish;
    end

endmodule
